### hdl/timed_mask_step_player_unit_defines.svh
// Assertion macros shared by the step player RTL.
`ifndef TIMED_MASK_STEP_PLAYER_UNIT_DEFINES_SVH
`define TIMED_MASK_STEP_PLAYER_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked.
`define TMSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define TMSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tmsp_pkg.sv
// Types and constants of the timed mask step player.
package tmsp_pkg;

    localparam int TIME_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PUSH  = 2'd1,
        REQ_GAP   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PAUSING = 3'b010,
        PH_RUNNING = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        ST_WAIT = 2'b01,
        ST_EXEC = 2'b10
    } t_ctl;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 2'd2;

endpackage

### hdl/timed_mask_step_player_unit.sv
// Top level: step queue in RAM played out against a millisecond tick.
// The step RAM is read when an item is accepted; the result is registered when it fires,
// which stalls while the output is held. No new item is accepted before that, as the
// registered read of the step RAM precedes each read-modify-write of queue and player state.
// Reset (synchronous, active low) clears pointers, fill count, phase, timers,
// config registers and handshake state; the step RAM is not cleared (fill count).
module timed_mask_step_player_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MASK_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tmsp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_req_type,
    input  logic [MASK_BITS-1:0]              i_step_mask,
    input  logic [tmsp_pkg::TIME_W-1:0]       i_hold_ms,
    input  logic [tmsp_pkg::TIME_W-1:0]       i_pause_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [MASK_BITS-1:0]              o_out_mask,
    output logic                              o_out_write,
    output logic                              o_active,
    output logic                              o_blocking,
    output logic                              o_dropped
);

    import tmsp_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = MASK_BITS + 2 * TIME_W;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    // config
    logic [TIME_W-1:0] r_def_on, r_def_off, r_gap;

    // handshake and item capture
    t_ctl                 r_ctl;
    t_req                 r_req;
    logic [MASK_BITS-1:0] r_mask;
    logic [TIME_W-1:0]    r_hold, r_pause;

    // player state
    logic [PTR_W-1:0]  r_head, r_tail, n_head, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_time_left, n_time_left;
    logic [TIME_W-1:0] r_off_delay, n_off_delay;

    // result register
    logic                 r_out_valid;
    logic [MASK_BITS-1:0] r_out_mask, n_out_mask;
    logic                 r_out_write, n_out_write;
    logic                 r_dropped, n_dropped;

    logic                 accept, fire, clear_fire;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic [MASK_BITS-1:0] rd_mask;
    logic [TIME_W-1:0]    rd_on, rd_off;

    assign o_in_ready = (r_ctl == ST_WAIT);
    assign accept     = i_in_valid && o_in_ready;
    assign fire       = (r_ctl == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign clear_fire = fire && (r_req == REQ_CLEAR);

    assign {rd_mask, rd_on, rd_off} = ram_rdata;

    tmsp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_step_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_tail),
        .i_wdata(ram_wdata),
        .i_re   (accept),
        .i_raddr(r_head),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        logic [TIME_W-1:0] h;
        logic [TIME_W-1:0] p;
        logic              do_push;

        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_time_left = r_time_left;
        n_off_delay = r_off_delay;
        n_out_mask  = '0;
        n_out_write = 1'b0;
        n_dropped   = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        h           = (r_hold == '0) ? r_def_on : r_hold;
        p           = (r_pause == '0) ? r_def_off : r_pause;
        do_push     = 1'b0;

        case (r_req)
            REQ_TICK: begin
                if (r_time_left != '0) begin
                    n_time_left = r_time_left - TIME_W'(1);
                end
                if (r_phase == PH_IDLE && r_fill != '0) begin
                    n_phase     = PH_PAUSING;
                    n_time_left = '0;
                end
                if (n_phase == PH_RUNNING && n_time_left == '0) begin
                    n_out_write = 1'b1;
                    n_phase     = PH_PAUSING;
                    n_time_left = r_off_delay;
                end else if (n_phase == PH_PAUSING && n_time_left == '0) begin
                    if (r_fill == '0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_head = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                        n_fill = r_fill - FILL_W'(1);
                        if (rd_mask == '0 && rd_on == '0) begin
                            n_time_left = rd_off;
                        end else begin
                            n_out_write = 1'b1;
                            n_out_mask  = rd_mask;
                            n_off_delay = rd_off;
                            n_time_left = rd_on;
                            n_phase     = PH_RUNNING;
                        end
                    end
                end
            end
            REQ_PUSH, REQ_GAP: begin
                if (r_req == REQ_PUSH) begin
                    do_push   = 1'b1;
                    ram_wdata = {r_mask, h, p};
                end else begin
                    do_push   = (r_fill != '0);
                    ram_wdata = {{MASK_BITS{1'b0}}, {TIME_W{1'b0}}, r_gap};
                end
                if (do_push) begin
                    if (r_fill == FILL_MAX) begin
                        n_dropped = 1'b1;
                    end else begin
                        ram_we = fire;
                        n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                if (r_phase == PH_IDLE) begin
                    n_phase     = PH_PAUSING;
                    n_time_left = '0;
                end
            end
            REQ_CLEAR: begin
                n_head      = '0;
                n_tail      = '0;
                n_fill      = '0;
                n_phase     = PH_IDLE;
                n_out_write = 1'b1;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_on  <= '0;
            r_def_off <= '0;
            r_gap     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEFAULT_ON:  r_def_on  <= i_cfg_data;
                CFG_DEFAULT_OFF: r_def_off <= i_cfg_data;
                CFG_GAP:         r_gap     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= t_req'(i_req_type);
            r_mask  <= i_step_mask;
            r_hold  <= i_hold_ms;
            r_pause <= i_pause_ms;
        end
        if (fire) begin
            r_out_mask  <= n_out_mask;
            r_out_write <= n_out_write;
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= ST_WAIT;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_off_delay <= '0;
        end else begin
            if (accept) begin
                r_ctl <= ST_EXEC;
            end else if (fire) begin
                r_ctl <= ST_WAIT;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_fill      <= n_fill;
                r_phase     <= n_phase;
                r_time_left <= n_time_left;
                r_off_delay <= n_off_delay;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_mask  = r_out_mask;
    assign o_out_write = r_out_write;
    assign o_active    = (r_phase != PH_IDLE);
    assign o_blocking  = (r_phase == PH_RUNNING);
    assign o_dropped   = r_dropped;

    `include "timed_mask_step_player_unit_defines.svh"

    `TMSP_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FILL_MAX, "fill count above depth")
    `TMSP_ASSERT_IMP(a_empty_ptrs, r_fill == '0, r_head == r_tail, "empty queue, pointers differ")
    `TMSP_ASSERT_NXT(a_clear_empties, clear_fire, !o_active && o_out_write, "clear left state")

endmodule

### hdl/tmsp_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
module tmsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### dv/tb.sv
// Self-checking testbench for the timed mask step player: predictor, scoreboard and drivers.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmsp_pkg::*;

    localparam int QDEPTH     = 64;
    localparam int MASK_W     = 16;
    localparam int CYCLE_CAP  = 400000;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] off_ms;
    } step_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              write;
        logic              active;
        logic              blocking;
        logic              dropped;
    } result_t;

    class step_player_scoreboard;
        step_t             steps[QDEPTH];
        logic [5:0]        head;
        logic [5:0]        tail;
        logic [6:0]        fill;
        t_phase            phase;
        logic [TIME_W-1:0] time_left;
        logic [TIME_W-1:0] off_delay;
        logic [MASK_W-1:0] drive_mask;
        logic [CFG_W-1:0]  def_on;
        logic [CFG_W-1:0]  def_off;
        logic [CFG_W-1:0]  gap_len;
        result_t           expected_q[$];
        int                errors;

        function new();
            head = '0;
            tail = '0;
            fill = '0;
            phase = PH_IDLE;
            time_left = '0;
            off_delay = '0;
            drive_mask = '0;
            def_on = '0;
            def_off = '0;
            gap_len = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_DEFAULT_ON:  def_on = value;
                CFG_DEFAULT_OFF: def_off = value;
                CFG_GAP:         gap_len = value;
                default: ;
            endcase
        endfunction

        function bit enqueue(logic [MASK_W-1:0] m, logic [TIME_W-1:0] on_ms,
                             logic [TIME_W-1:0] off_ms);
            if (fill == QDEPTH)
                return 1'b0;
            steps[tail] = '{m, on_ms, off_ms};
            tail = tail + 1'b1;
            fill = fill + 1'b1;
            return 1'b1;
        endfunction

        function void wake();
            if (phase == PH_IDLE) begin
                phase = PH_PAUSING;
                time_left = '0;
            end
        endfunction

        function void note_input(t_req req, logic [MASK_W-1:0] m, logic [TIME_W-1:0] hold,
                                 logic [TIME_W-1:0] pause);
            result_t           r;
            step_t             s;
            logic [TIME_W-1:0] h;
            logic [TIME_W-1:0] p;
            r = '0;
            case (req)
                REQ_TICK: begin
                    if (time_left != 0)
                        time_left = time_left - 1'b1;
                    if (phase == PH_IDLE && fill != 0) begin
                        phase = PH_PAUSING;
                        time_left = '0;
                    end
                    if (phase == PH_RUNNING && time_left == 0) begin
                        r.write = 1'b1;
                        phase = PH_PAUSING;
                        time_left = off_delay;
                        drive_mask = '0;
                    end else if (phase == PH_PAUSING && time_left == 0) begin
                        if (fill == 0) begin
                            phase = PH_IDLE;
                        end else begin
                            s = steps[head];
                            head = head + 1'b1;
                            fill = fill - 1'b1;
                            if (s.mask == 0 && s.on_ms == 0) begin
                                time_left = s.off_ms;
                            end else begin
                                drive_mask = s.mask;
                                r.write = 1'b1;
                                r.mask = s.mask;
                                off_delay = s.off_ms;
                                time_left = s.on_ms;
                                phase = PH_RUNNING;
                            end
                        end
                    end
                end
                REQ_PUSH: begin
                    h = (hold == 0) ? def_on : hold;
                    p = (pause == 0) ? def_off : pause;
                    r.dropped = !enqueue(m, h, p);
                    wake();
                end
                REQ_GAP: begin
                    if (fill != 0)
                        r.dropped = !enqueue('0, '0, gap_len);
                    wake();
                end
                default: begin
                    head = '0;
                    tail = '0;
                    fill = '0;
                    phase = PH_IDLE;
                    drive_mask = '0;
                    r.write = 1'b1;
                end
            endcase
            r.active = (phase != PH_IDLE);
            r.blocking = (phase == PH_RUNNING);
            expected_q = {expected_q, r};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result beat: %h %b %b %b %b", $time,
                             got.mask, got.write, got.active, got.blocking, got.dropped);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch: exp %h %b %b %b %b, got %h %b %b %b %b",
                             $time, want.mask, want.write, want.active, want.blocking,
                             want.dropped, got.mask, got.write, got.active, got.blocking,
                             got.dropped);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 o_in_ready;
    t_req                 in_req;
    logic [MASK_W-1:0]    in_mask;
    logic [TIME_W-1:0]    in_hold;
    logic [TIME_W-1:0]    in_pause;
    logic                 o_out_valid;
    logic                 out_ready;
    logic [MASK_W-1:0]    o_out_mask;
    logic                 o_out_write;
    logic                 o_active;
    logic                 o_blocking;
    logic                 o_dropped;

    step_player_scoreboard sb = new();
    int cycle_count = 0;
    int quiet_in = 0;
    int quiet_out = 0;

    timed_mask_step_player_unit #(
        .QUEUE_DEPTH (QDEPTH),
        .MASK_BITS   (MASK_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (in_req),
        .i_step_mask (in_mask),
        .i_hold_ms   (in_hold),
        .i_pause_ms  (in_pause),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_mask  (o_out_mask),
        .o_out_write (o_out_write),
        .o_active    (o_active),
        .o_blocking  (o_blocking),
        .o_dropped   (o_dropped)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timed_mask_step_player_unit test failed");
            $finish;
        end
    end

    // input beats, register writes and result beats, all sampled at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we)
                sb.write_reg(cfg_idx, cfg_data);
            if (in_valid && o_in_ready)
                sb.note_input(in_req, in_mask, in_hold, in_pause);
            if (o_out_valid && out_ready)
                sb.check_result('{o_out_mask, o_out_write, o_active, o_blocking, o_dropped});
        end
    end

    // random idle gap before each beat, with occasional stretches of back-to-back beats
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 4)
            return '0;
        if (pick < 15)
            return TIME_W'($urandom_range(1, 6));
        return TIME_W'($urandom);
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        if ($urandom_range(0, 7) == 0)
            return '0;
        return MASK_W'($urandom);
    endfunction

    initial begin
        int stall;
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(quiet_out);
            repeat (stall) begin
                out_ready <= 1'b0;
                @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // entered and left at a falling edge; valid stays high for a following beat
    task automatic send_item(t_req req, logic [MASK_W-1:0] m, logic [TIME_W-1:0] hold,
                             logic [TIME_W-1:0] pause);
        int gap;
        gap = draw_wait(quiet_in);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        in_mask  <= m;
        in_hold  <= hold;
        in_pause <= pause;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, MASK_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] on_ms, logic [CFG_W-1:0] off_ms,
                                logic [CFG_W-1:0] gap_ms);
        write_reg(CFG_DEFAULT_ON, on_ms);
        write_reg(CFG_DEFAULT_OFF, off_ms);
        write_reg(CFG_GAP, gap_ms);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random(int count);
        int sent;
        int kind;
        int n;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 19);
            if (kind <= 10) begin
                // one letter: a few steps, maybe gaps, then enough ticks to play some out
                n = $urandom_range(1, 5);
                repeat (n) begin
                    send_item(REQ_PUSH, rand_mask(), rand_time(), rand_time());
                    sent++;
                    if ($urandom_range(0, 3) == 0) begin
                        send_item(REQ_GAP, MASK_W'($urandom), TIME_W'($urandom),
                                  TIME_W'($urandom));
                        sent++;
                    end
                end
                n = $urandom_range(3, 40);
                repeat (n) begin
                    send_tick();
                    sent++;
                end
            end else if (kind <= 13) begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    send_item(t_req'($urandom_range(0, 3)), MASK_W'($urandom),
                              TIME_W'($urandom), TIME_W'($urandom));
                    sent++;
                end
            end else if (kind <= 15) begin
                send_item(REQ_CLEAR, MASK_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
                sent++;
            end else if (kind <= 18) begin
                n = $urandom_range(1, 60);
                repeat (n) begin
                    send_tick();
                    sent++;
                end
            end else begin
                // overrun the queue
                n = $urandom_range(60, 70);
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0)
                        send_item(REQ_GAP, '0, '0, '0);
                    else
                        send_item(REQ_PUSH, rand_mask(), rand_time(), rand_time());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_DEFAULT_ON;
        cfg_data = '0;
        in_valid = 1'b0;
        in_req   = REQ_TICK;
        in_mask  = '0;
        in_hold  = '0;
        in_pause = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        program_regs(16'd0, 16'd2, 16'd3);
        send_tick();                                    // idle, empty
        send_item(REQ_GAP, 16'hFFFF, 16'hFFFF, 16'hFFFF); // gap on empty queue
        send_tick();                                    // back to idle
        send_item(REQ_PUSH, 16'h0000, 16'h0000, 16'h0000); // silent step
        send_item(REQ_GAP, 16'h0000, 16'h0000, 16'h0000);
        send_item(REQ_PUSH, 16'hFFFF, 16'h0000, 16'h0000); // defaults, zero on time
        send_item(REQ_PUSH, 16'h0000, 16'h0001, 16'h0001); // driven zero mask
        send_item(REQ_PUSH, 16'h8001, 16'h0002, 16'h0001);
        repeat (14) send_tick();
        send_item(REQ_PUSH, 16'h5AA5, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_tick();
        send_item(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000); // clear while running
        send_tick();

        wait_drained();
        program_regs(16'd0, 16'd0, 16'd0);
        run_random(150);

        wait_drained();
        program_regs(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 6)),
                     CFG_W'($urandom_range(1, 6)));
        run_random(150);

        wait_drained();
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(150);

        wait_drained();
        program_regs(16'd0, CFG_W'($urandom_range(1, 5)), CFG_W'($urandom_range(1, 5)));
        run_random(150);

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("timed_mask_step_player_unit test passed");
        end else begin
            $display("timed_mask_step_player_unit test failed");
        end
        $finish;
    end

endmodule
